// File: rtl/core/tmcw_pkg.sv
// tmcw_pkg: shared types and constants of the text-mode console writer
// command codes, character codes, cell constants, item and result words
// depends on nothing; imported by tmcw_seq and text_mode_console_writer
package tmcw_pkg;

  // command codes
  localparam logic [1:0] CMD_PUT   = 2'd0;
  localparam logic [1:0] CMD_CLEAR = 2'd1;
  localparam logic [1:0] CMD_READ  = 2'd2;

  // control characters and blanks
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_NL    = 8'h0A;
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_SPACE = 8'h20;

  // grey space written by the power-on sweep
  localparam logic [15:0] RESET_CELL = 16'h0720;

  // configuration register indexes and reset colours
  localparam logic [1:0] REG_FG   = 2'd0;
  localparam logic [1:0] REG_BG   = 2'd1;
  localparam logic [3:0] FG_RESET = 4'h7;
  localparam logic [3:0] BG_RESET = 4'h0;

  // field widths
  localparam int CMD_W  = 2;
  localparam int CHAR_W = 8;
  localparam int ADDR_W = 11;
  localparam int CELL_W = 16;

  // one input word, as a packed struct of its fields
  typedef struct packed {
    logic [ADDR_W-1:0] cell_address;
    logic [CHAR_W-1:0] char_code;
    logic [CMD_W-1:0]  command;
  } tmcw_item_t;

  // one result word, as a packed struct of its fields
  typedef struct packed {
    logic [CELL_W-1:0] cell_value;
    logic [ADDR_W-1:0] cursor_index;
  } tmcw_res_t;

endpackage

// File: rtl/core/tmcw_ram.sv
// tmcw_ram: generic single-clock ram, one write port and one registered read port
// read data appears in the cycle after the address
// depends on nothing
module tmcw_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 2000
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  // write and registered read
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_addr] <= wr_data;
    end
    rd_data_r <= mem_r[rd_addr];
  end

  assign rd_data = rd_data_r;

endmodule

// File: rtl/core/tmcw_seq.sv
// tmcw_seq: command sequencer of the console writer; owns cursor and screen ram
// runs the power-on sweep, character stores, scroll copy, fills and cell reads
// depends on tmcw_pkg and tmcw_ram
module tmcw_seq #(
  parameter int COLUMNS = 80,
  parameter int ROWS    = 25
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 item_valid,
  output logic                 item_ready,
  input  tmcw_pkg::tmcw_item_t item,
  input  logic [7:0]           attr,
  output logic                 res_valid,
  input  logic                 res_take,
  output tmcw_pkg::tmcw_res_t  res
);
  import tmcw_pkg::*;

  localparam int CELLS    = COLUMNS * ROWS;
  localparam int AW       = $clog2(CELLS);
  localparam int CUR_W    = $clog2(CELLS + 1);
  localparam int CW       = $clog2(COLUMNS);
  localparam int LAST_ROW = CELLS - COLUMNS;
  localparam int XW       = CUR_W + ADDR_W;

  typedef enum logic [2:0] {
    S_INIT, S_IDLE, S_READ, S_STORE, S_COPY, S_FILL, S_DONE
  } state_t;

  state_t              state_r,  state_nxt;
  logic [CUR_W-1:0]    ptr_r,    ptr_nxt;
  logic [CUR_W-1:0]    cursor_r, cursor_nxt;
  logic [CW-1:0]       col_r,    col_nxt;
  logic [2:0]          reps_r,   reps_nxt;
  logic [CHAR_W-1:0]   ch_r,     ch_nxt;
  logic                rd_ok_r,  rd_ok_nxt;
  logic [CELL_W-1:0]   val_r,    val_nxt;
  logic                rd_vld_r, rd_vld_nxt;
  logic [AW-1:0]       dst_r,    dst_nxt;

  logic                we;
  logic [AW-1:0]       waddr;
  logic [CELL_W-1:0]   wdata;
  logic [AW-1:0]       raddr;
  logic [CELL_W-1:0]   rdata;
  logic [CELL_W-1:0]   blank;
  logic [XW-1:0]       addr_ext;
  logic [CUR_W-1:0]    col_ext;
  logic [CUR_W-1:0]    src_back;

  // screen memory
  tmcw_ram #(
    .WIDTH (CELL_W),
    .DEPTH (CELLS)
  ) u_screen (
    .clk     (clk),
    .wr_en   (we),
    .wr_addr (waddr),
    .wr_data (wdata),
    .rd_addr (raddr),
    .rd_data (rdata)
  );

  assign blank    = {attr, CH_SPACE};
  assign addr_ext = XW'(item.cell_address);
  assign col_ext  = CUR_W'(col_r);
  assign src_back = ptr_r - CUR_W'(COLUMNS);

  // next-state and memory port logic
  always_comb begin
    state_nxt  = state_r;
    ptr_nxt    = ptr_r;
    cursor_nxt = cursor_r;
    col_nxt    = col_r;
    reps_nxt   = reps_r;
    ch_nxt     = ch_r;
    rd_ok_nxt  = rd_ok_r;
    val_nxt    = val_r;
    rd_vld_nxt = 1'b0;
    dst_nxt    = src_back[AW-1:0];
    we         = 1'b0;
    waddr      = ptr_r[AW-1:0];
    wdata      = blank;
    raddr      = ptr_r[AW-1:0];

    case (state_r)
      // power-on sweep of grey spaces
      S_INIT: begin
        we    = 1'b1;
        wdata = RESET_CELL;
        if (ptr_r == CUR_W'(CELLS - 1)) begin
          ptr_nxt   = '0;
          state_nxt = S_IDLE;
        end else begin
          ptr_nxt = ptr_r + 1'b1;
        end
      end

      // take a command word
      S_IDLE: begin
        raddr = addr_ext[AW-1:0];
        if (item_valid) begin
          val_nxt = '0;
          case (item.command)
            CMD_PUT: begin
              if (item.char_code == CH_NL) begin
                col_nxt  = '0;
                reps_nxt = '0;
                if (cursor_r >= CUR_W'(LAST_ROW)) begin
                  cursor_nxt = CUR_W'(LAST_ROW);
                  ptr_nxt    = CUR_W'(COLUMNS);
                  state_nxt  = S_COPY;
                end else begin
                  cursor_nxt = cursor_r - col_ext + CUR_W'(COLUMNS);
                  state_nxt  = S_DONE;
                end
              end else if (item.char_code == CH_CR) begin
                cursor_nxt = cursor_r - col_ext;
                col_nxt    = '0;
                state_nxt  = S_DONE;
              end else if (item.char_code == CH_TAB) begin
                ch_nxt    = CH_SPACE;
                reps_nxt  = 3'd4;
                state_nxt = S_STORE;
              end else begin
                ch_nxt    = item.char_code;
                reps_nxt  = 3'd1;
                state_nxt = S_STORE;
              end
            end
            CMD_CLEAR: begin
              ptr_nxt    = '0;
              cursor_nxt = '0;
              col_nxt    = '0;
              reps_nxt   = '0;
              state_nxt  = S_FILL;
            end
            CMD_READ: begin
              rd_ok_nxt = addr_ext < XW'(CELLS);
              state_nxt = S_READ;
            end
            default: begin
              state_nxt = S_DONE;
            end
          endcase
        end
      end

      // read data is back
      S_READ: begin
        val_nxt   = rd_ok_r ? rdata : '0;
        state_nxt = S_DONE;
      end

      // store one character at the cursor and advance; a store at the last cell scrolls
      S_STORE: begin
        we       = 1'b1;
        waddr    = cursor_r[AW-1:0];
        wdata    = {attr, ch_r};
        reps_nxt = reps_r - 1'b1;
        if (cursor_r == CUR_W'(CELLS - 1)) begin
          cursor_nxt = CUR_W'(LAST_ROW);
          col_nxt    = '0;
          ptr_nxt    = CUR_W'(COLUMNS);
          state_nxt  = S_COPY;
        end else begin
          cursor_nxt = cursor_r + 1'b1;
          col_nxt    = (col_r == CW'(COLUMNS - 1)) ? '0 : col_r + 1'b1;
          if (reps_r == 3'd1) begin
            state_nxt = S_DONE;
          end
        end
      end

      // scroll: read a cell one row down, then write it back one row up
      S_COPY: begin
        if (rd_vld_r) begin
          we    = 1'b1;
          waddr = dst_r;
          wdata = rdata;
        end
        if (ptr_r == CUR_W'(CELLS)) begin
          ptr_nxt   = CUR_W'(LAST_ROW);
          state_nxt = S_FILL;
        end else begin
          rd_vld_nxt = 1'b1;
          ptr_nxt    = ptr_r + 1'b1;
        end
      end

      // blank fill up to the end of the screen
      S_FILL: begin
        we = 1'b1;
        if (ptr_r == CUR_W'(CELLS - 1)) begin
          state_nxt = (reps_r == '0) ? S_DONE : S_STORE;
        end else begin
          ptr_nxt = ptr_r + 1'b1;
        end
      end

      // hand the result word over
      S_DONE: begin
        if (res_take) begin
          state_nxt = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // state and registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= S_INIT;
      ptr_r    <= '0;
      cursor_r <= '0;
      col_r    <= '0;
      reps_r   <= '0;
      rd_vld_r <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      ptr_r    <= ptr_nxt;
      cursor_r <= cursor_nxt;
      col_r    <= col_nxt;
      reps_r   <= reps_nxt;
      rd_vld_r <= rd_vld_nxt;
    end
    ch_r    <= ch_nxt;
    rd_ok_r <= rd_ok_nxt;
    val_r   <= val_nxt;
    dst_r   <= dst_nxt;
  end

  assign item_ready       = (state_r == S_IDLE);
  assign res_valid        = (state_r == S_DONE);
  assign res.cursor_index = ADDR_W'(cursor_r);
  assign res.cell_value   = val_r;

  // cursor stays on the screen
  a_cursor_range: assert property (@(posedge clk) disable iff (!rst_n)
    cursor_r < CUR_W'(CELLS))
    else $error("cursor beyond last cell");

  // column counter matches a real column
  a_col_range: assert property (@(posedge clk) disable iff (!rst_n)
    col_r < CW'(COLUMNS) || COLUMNS == (1 << CW))
    else $error("column counter out of range");

  // copy write-back only follows a copy read
  a_copy_pipe: assert property (@(posedge clk) disable iff (!rst_n)
    rd_vld_r |-> $past(state_r) == S_COPY)
    else $error("copy write without a copy read");

  // a taken result frees the sequencer
  a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_DONE && res_take) |=> state_r == S_IDLE)
    else $error("sequencer not idle after result handover");

endmodule

// File: rtl/core/text_mode_console_writer.sv
// text_mode_console_writer: top level of the text-mode console writer
// colour registers, input handshake and result register around the sequencer
// depends on tmcw_pkg and tmcw_seq
//
//  channel | direction | handshake             | payload
//  in_     | input     | in_tvalid/in_tready   | in_tdata: command, char_code, cell_address
//  out_    | output    | out_tvalid/out_tready | out_tdata: cursor_index, cell_value
//  cfg_    | input     | cfg_valid/cfg_ready   | cfg_index, cfg_data
//
// after reset a sweep writes grey spaces over all COLUMNS*ROWS cells; no word is taken meanwhile
// ordinary character: one store, then the result; return and unused command go straight to the result
// read: a ram read, then the result; tab: spaces, each stored like an ordinary character
// newline on the last row, or a store at the last cell, scrolls the screen up by one row; clear blanks
// every cell; scroll and clear both go cell by cell through the single write port of the screen ram
// one word at a time; the next word is taken while a result waits in the output register; configuration is always ready
module text_mode_console_writer #(
  parameter int COLUMNS = 80,
  parameter int ROWS    = 25
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [23:0] in_tdata,   // command[1:0], char_code[9:2], cell_address[20:10]
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [31:0] out_tdata,  // cursor_index[10:0], cell_value[26:11]
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [3:0]  cfg_data
);
  import tmcw_pkg::*;

  logic       fg_r;
  logic [3:0] fg_col_r;
  logic [3:0] bg_col_r;
  logic       out_tvalid_r;
  logic [31:0] out_tdata_r;
  tmcw_item_t item;
  tmcw_res_t  res;
  logic       res_valid;
  logic       res_take;

  assign item = in_tdata[20:0];

  // sequencer with the screen memory
  tmcw_seq #(
    .COLUMNS (COLUMNS),
    .ROWS    (ROWS)
  ) u_seq (
    .clk        (clk),
    .rst_n      (rst_n),
    .item_valid (in_tvalid),
    .item_ready (in_tready),
    .item       (item),
    .attr       ({bg_col_r, fg_col_r}),
    .res_valid  (res_valid),
    .res_take   (res_take),
    .res        (res)
  );

  assign res_take  = res_valid && (!out_tvalid_r || out_tready);
  assign cfg_ready = 1'b1;

  // colour registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fg_col_r <= FG_RESET;
      bg_col_r <= BG_RESET;
      fg_r     <= 1'b0;
    end else begin
      fg_r <= cfg_valid && (cfg_index == REG_FG);
      if (cfg_valid) begin
        case (cfg_index)
          REG_FG:  fg_col_r <= cfg_data;
          REG_BG:  bg_col_r <= cfg_data;
          default: ;
        endcase
      end
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_tvalid_r <= 1'b0;
    end else if (res_take) begin
      out_tvalid_r <= 1'b1;
    end else if (out_tready) begin
      out_tvalid_r <= 1'b0;
    end
    if (res_take) begin
      out_tdata_r <= {5'b0, res};
    end
  end

  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = out_tdata_r;

  // a result is only loaded into a free or draining output register
  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid_r && !out_tready) |=> $stable(out_tdata_r))
    else $error("pending result overwritten");

  // each handed-over result shows up as a valid word
  a_load_valid: assert property (@(posedge clk) disable iff (!rst_n)
    res_take |=> out_tvalid_r)
    else $error("result lost at output register");

  // foreground write flag follows only an accepted index-zero write
  a_fg_write: assert property (@(posedge clk) disable iff (!rst_n)
    fg_r |-> fg_col_r == $past(cfg_data))
    else $error("foreground register not loaded");

endmodule
